// ===== rtl/wftf_pkg.sv =====
package wftf_pkg;

    localparam int MAX_FILTERS_DEFAULT = 16;

    localparam logic [1:0] OP_MATCH  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  addr_family;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
        logic [7:0]  proto_in;
        logic [3:0]  entry_index;
    } req_t;

    typedef struct packed {
        logic       matched;
        logic [1:0] status;
        logic [4:0] entries_used;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  family;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } filt_t;

    // Strobes broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic match_load;
        logic sweep_en;
        logic add_en;
        logic remove_en;
    } ctl_t;

endpackage

// ===== rtl/wildcard_five_tuple_filter.sv =====
// Match: with filters loaded, one compare in every cell, then the hit ripples down
// the cell chain one cell a cycle to cell zero; an empty table reports a match at once.
// Add, remove and other ops go straight to the result state.
// Throughput: one transaction at a time, taken the cycle after the previous result
// loads the output register; a result waits while that register is still held.
// Reset: rst_n clears the filter count, sequencer and output valid; filters stay.
module wildcard_five_tuple_filter #(
    parameter int MAX_FILTERS = wftf_pkg::MAX_FILTERS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  wftf_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output wftf_pkg::rsp_t  rsp
);

    localparam int CW  = $clog2(MAX_FILTERS + 1);
    localparam int SCW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [SCW-1:0] sweep_reg, sweep_next;
    logic           res_matched_reg, res_matched_next;
    logic           res_sweep_reg, res_sweep_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic           rsp_valid_reg, rsp_valid_next;
    wftf_pkg::rsp_t rsp_reg, rsp_next;

    wftf_pkg::ctl_t  ctl;
    wftf_pkg::filt_t entry_out [MAX_FILTERS];
    logic            acc_out   [MAX_FILTERS];

    logic accept;
    logic full;
    logic empty;
    logic idx_ok;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == CW'(MAX_FILTERS));
    assign empty     = (count_reg == '0);
    assign idx_ok    = int'(req.entry_index) < int'(count_reg);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        sweep_next       = sweep_reg;
        res_matched_next = res_matched_reg;
        res_sweep_next   = res_sweep_reg;
        res_status_next  = res_status_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;
        ctl              = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_matched_next = 1'b0;
                    res_sweep_next   = 1'b0;
                    res_status_next  = wftf_pkg::ST_OK;
                    state_next       = S_DONE;
                    priority if (req.op == wftf_pkg::OP_MATCH)
                    begin
                        if (empty)
                        begin
                            res_matched_next = 1'b1;
                        end
                        else
                        begin
                            ctl.match_load = 1'b1;
                            res_sweep_next = 1'b1;
                            sweep_next     = '0;
                            state_next     = S_SWEEP;
                        end
                    end
                    else if (req.op == wftf_pkg::OP_ADD)
                    begin
                        if (full)
                        begin
                            res_status_next = wftf_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.add_en = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (req.op == wftf_pkg::OP_REMOVE)
                    begin
                        if (!idx_ok)
                        begin
                            res_status_next = wftf_pkg::ST_BAD_INDEX;
                        end
                        else
                        begin
                            ctl.remove_en = 1'b1;
                            count_next    = count_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        // unknown op: report ok, change nothing
                    end
                end
            end
            S_SWEEP:
            begin
                ctl.sweep_en = 1'b1;
                sweep_next   = sweep_reg + SCW'(1);
                if (sweep_reg == SCW'(MAX_FILTERS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.matched      = res_matched_reg | (res_sweep_reg & acc_out[0]);
                    rsp_next.status       = res_status_reg;
                    rsp_next.entries_used = 5'(count_reg);
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_reg       <= sweep_next;
        res_matched_reg <= res_matched_next;
        res_sweep_reg   <= res_sweep_next;
        res_status_reg  <= res_status_next;
        rsp_reg         <= rsp_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FILTERS; gi++)
        begin : g_cell
            wftf_pkg::filt_t nbr_entry;
            logic            nbr_acc;
            if (gi == MAX_FILTERS - 1)
            begin : g_last
                assign nbr_entry = entry_out[gi];
                assign nbr_acc   = 1'b0;
            end
            else
            begin : g_mid
                assign nbr_entry = entry_out[gi + 1];
                assign nbr_acc   = acc_out[gi + 1];
            end
            wftf_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .count      (count_reg),
                .req        (req),
                .next_entry (nbr_entry),
                .acc_in     (nbr_acc),
                .entry      (entry_out[gi]),
                .acc        (acc_out[gi])
            );
        end
    endgenerate

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_FILTERS)
        else $error("filter count above table size");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("filter count changed without a transaction");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside the done state");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status == wftf_pkg::ST_FULL)
            |-> (rsp_reg.entries_used == 5'(MAX_FILTERS)))
        else $error("table full reported with free entries");

endmodule

// ===== rtl/wftf_cell.sv =====
module wftf_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                clk,
    input  wftf_pkg::ctl_t      ctl,
    input  logic [CW-1:0]       count,
    input  wftf_pkg::req_t      req,
    input  wftf_pkg::filt_t     next_entry,
    input  logic                acc_in,
    output wftf_pkg::filt_t     entry,
    output logic                acc
);

    wftf_pkg::filt_t entry_reg;
    logic            hit_reg;
    logic            acc_reg;

    logic valid;
    logic has_addr;
    logic fam_ok;
    logic proto_ok;
    logic src_wild;
    logic dst_wild;
    logic fwd;
    logic rev;
    logic hit;
    logic [127:0] f_src;
    logic [127:0] f_dst;
    logic [127:0] p_src;
    logic [127:0] p_dst;

    assign valid = int'(count) > IDX;

    always_comb
    begin
        f_src    = {entry_reg.src_hi, entry_reg.src_lo};
        f_dst    = {entry_reg.dst_hi, entry_reg.dst_lo};
        p_src    = {req.src_addr_hi, req.src_addr_lo};
        p_dst    = {req.dst_addr_hi, req.dst_addr_lo};
        src_wild = (f_src == 128'd0);
        dst_wild = (f_dst == 128'd0);
        has_addr = !src_wild || !dst_wild;
        fam_ok   = !has_addr || (entry_reg.family == req.addr_family);
        proto_ok = (entry_reg.proto == 8'd0) || (entry_reg.proto == req.proto_in);
        fwd = (src_wild || (f_src == p_src)) &&
              (dst_wild || (f_dst == p_dst)) &&
              ((entry_reg.sport == 16'd0) || (entry_reg.sport == req.src_l4_port)) &&
              ((entry_reg.dport == 16'd0) || (entry_reg.dport == req.dst_l4_port));
        rev = (src_wild || (f_src == p_dst)) &&
              (dst_wild || (f_dst == p_src)) &&
              ((entry_reg.sport == 16'd0) || (entry_reg.sport == req.dst_l4_port)) &&
              ((entry_reg.dport == 16'd0) || (entry_reg.dport == req.src_l4_port));
        hit = valid && fam_ok && proto_ok && (fwd || rev);
    end

    // Compare against the broadcast tuple, then ripple the hit toward cell zero.
    always_ff @(posedge clk)
    begin
        if (ctl.match_load)
        begin
            hit_reg <= hit;
            acc_reg <= 1'b0;
        end
        else if (ctl.sweep_en)
        begin
            acc_reg <= hit_reg | acc_in;
        end
    end

    // Append at the tail, or take the upper neighbor's filter on a remove.
    always_ff @(posedge clk)
    begin
        if (ctl.add_en && (int'(count) == IDX))
        begin
            entry_reg.family <= req.addr_family;
            entry_reg.src_hi <= req.src_addr_hi;
            entry_reg.src_lo <= req.src_addr_lo;
            entry_reg.dst_hi <= req.dst_addr_hi;
            entry_reg.dst_lo <= req.dst_addr_lo;
            entry_reg.sport  <= req.src_l4_port;
            entry_reg.dport  <= req.dst_l4_port;
            entry_reg.proto  <= req.proto_in;
        end
        else if (ctl.remove_en && (int'(req.entry_index) <= IDX))
        begin
            entry_reg <= next_entry;
        end
    end

    assign entry = entry_reg;
    assign acc   = acc_reg;

endmodule

// ===== sim/wildcard_five_tuple_filter_test.sv =====
module wildcard_five_tuple_filter_test;

    localparam int MAX_FILTERS = wftf_pkg::MAX_FILTERS_DEFAULT;
    localparam int RANDOM_ITEMS = 1030;
    localparam int CALM_TAIL = 150;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 250;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_V4   = 2'd1;
    localparam logic [1:0] FAM_V6   = 2'd2;
    localparam logic [1:0] FAM_ODD  = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    wftf_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    wftf_pkg::rsp_t rsp;

    wftf_pkg::req_t pending_reqs[$];
    wftf_pkg::rsp_t expected_rsps[$];
    wftf_pkg::req_t stim_table[$];
    wftf_pkg::filt_t filter_table[$];

    int n_total = 0;
    int n_sent = 0;
    int n_results = 0;
    int errors = 0;
    int n_matches = 0;
    int n_hits = 0;
    int n_adds = 0;
    int n_full = 0;
    int n_removes = 0;
    int n_bad = 0;

    int send_gap = 0;
    int recv_stall = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    logic quiet = 1'b0;
    wftf_pkg::rsp_t want;

    wildcard_five_tuple_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Zero in the filter field is a wildcard, else an exact compare.
    function automatic bit wild_eq(logic [127:0] f, logic [127:0] p);
        return f == '0 || f == p;
    endfunction

    function automatic bit filter_hits(wftf_pkg::filt_t f, wftf_pkg::req_t r);
        logic [127:0] fs;
        logic [127:0] fd;
        logic [127:0] ps;
        logic [127:0] pd;
        bit fwd;
        bit rev;
        fs = {f.src_hi, f.src_lo};
        fd = {f.dst_hi, f.dst_lo};
        ps = {r.src_addr_hi, r.src_addr_lo};
        pd = {r.dst_addr_hi, r.dst_addr_lo};
        // A filter that names an address only applies to its own family
        if ((fs != '0 || fd != '0) && f.family != r.addr_family)
            return 1'b0;
        if (!wild_eq(128'(f.proto), 128'(r.proto_in)))
            return 1'b0;
        fwd = wild_eq(fs, ps) && wild_eq(fd, pd)
            && wild_eq(128'(f.sport), 128'(r.src_l4_port))
            && wild_eq(128'(f.dport), 128'(r.dst_l4_port));
        rev = wild_eq(fs, pd) && wild_eq(fd, ps)
            && wild_eq(128'(f.sport), 128'(r.dst_l4_port))
            && wild_eq(128'(f.dport), 128'(r.src_l4_port));
        return fwd || rev;
    endfunction

    // Update the table copy with one transaction and return its result.
    function automatic wftf_pkg::rsp_t apply_request(wftf_pkg::req_t r);
        wftf_pkg::rsp_t o;
        wftf_pkg::filt_t f;
        o = '0;
        case (r.op)
            wftf_pkg::OP_MATCH:
            begin
                n_matches++;
                o.matched = (filter_table.size() == 0);
                foreach (filter_table[i])
                    if (filter_hits(filter_table[i], r))
                        o.matched = 1'b1;
                if (o.matched)
                    n_hits++;
            end
            wftf_pkg::OP_ADD:
            begin
                n_adds++;
                if (filter_table.size() >= MAX_FILTERS)
                begin
                    o.status = wftf_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    f.family = r.addr_family;
                    f.src_hi = r.src_addr_hi;
                    f.src_lo = r.src_addr_lo;
                    f.dst_hi = r.dst_addr_hi;
                    f.dst_lo = r.dst_addr_lo;
                    f.sport = r.src_l4_port;
                    f.dport = r.dst_l4_port;
                    f.proto = r.proto_in;
                    filter_table.push_back(f);
                end
            end
            wftf_pkg::OP_REMOVE:
            begin
                n_removes++;
                if (r.entry_index >= filter_table.size())
                begin
                    o.status = wftf_pkg::ST_BAD_INDEX;
                    n_bad++;
                end
                else
                    filter_table.delete(r.entry_index);
            end
            default: ;
        endcase
        o.entries_used = 5'(filter_table.size());
        return o;
    endfunction

    function automatic wftf_pkg::req_t mk(logic [1:0] op, logic [1:0] fam, logic [63:0] shi,
                                          logic [63:0] slo, logic [63:0] dhi,
                                          logic [63:0] dlo, logic [15:0] sp,
                                          logic [15:0] dp, logic [7:0] pr,
                                          logic [3:0] idx);
        wftf_pkg::req_t r;
        r.op = op;
        r.addr_family = fam;
        r.src_addr_hi = shi;
        r.src_addr_lo = slo;
        r.dst_addr_hi = dhi;
        r.dst_addr_lo = dlo;
        r.src_l4_port = sp;
        r.dst_l4_port = dp;
        r.proto_in = pr;
        r.entry_index = idx;
        return r;
    endfunction

    function automatic logic [127:0] rand_addr(logic [1:0] fam);
        if (fam == FAM_V4)
            return {96'd0, 32'($urandom)};
        return {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
    endfunction

    function automatic wftf_pkg::req_t random_noise();
        wftf_pkg::req_t r;
        r = '0;
        for (int k = 0; k < 10; k++)
            r = {r[$bits(wftf_pkg::req_t)-33:0], 32'($urandom)};
        return r;
    endfunction

    function automatic wftf_pkg::req_t random_filter();
        wftf_pkg::req_t f;
        int pick;
        f = '0;
        f.op = wftf_pkg::OP_ADD;
        pick = $urandom_range(0, 9);
        f.addr_family = pick < 4 ? FAM_V4 : pick < 8 ? FAM_V6 : pick == 8 ? FAM_NONE : FAM_ODD;
        if ($urandom_range(0, 9) >= 3)
            {f.src_addr_hi, f.src_addr_lo} = rand_addr(f.addr_family);
        if ($urandom_range(0, 9) >= 3)
            {f.dst_addr_hi, f.dst_addr_lo} = rand_addr(f.addr_family);
        if ($urandom_range(0, 9) >= 3)
            f.src_l4_port = 16'($urandom);
        if ($urandom_range(0, 9) >= 3)
            f.dst_l4_port = 16'($urandom);
        if ($urandom_range(0, 9) >= 3)
            f.proto_in = $urandom_range(0, 2) == 0 ? 8'($urandom)
                       : $urandom_range(0, 1) ? 8'd6 : 8'd17;
        f.entry_index = 4'($urandom);
        return f;
    endfunction

    function automatic wftf_pkg::req_t random_packet();
        wftf_pkg::req_t p;
        p = random_filter();
        p.op = wftf_pkg::OP_MATCH;
        if ($urandom_range(0, 3) == 0)
            p.addr_family = 2'($urandom);
        return p;
    endfunction

    // Build a packet that hits the given filter, swapped or slightly off.
    function automatic wftf_pkg::req_t packet_for(wftf_pkg::req_t f);
        wftf_pkg::req_t p;
        logic [63:0] t_hi;
        logic [63:0] t_lo;
        logic [15:0] t_port;
        p = f;
        p.op = wftf_pkg::OP_MATCH;
        p.entry_index = 4'($urandom);
        if ({f.src_addr_hi, f.src_addr_lo, f.dst_addr_hi, f.dst_addr_lo} == '0)
            p.addr_family = 2'($urandom);
        if ({p.src_addr_hi, p.src_addr_lo} == '0)
            {p.src_addr_hi, p.src_addr_lo} = rand_addr(p.addr_family);
        if ({p.dst_addr_hi, p.dst_addr_lo} == '0)
            {p.dst_addr_hi, p.dst_addr_lo} = rand_addr(p.addr_family);
        if (p.src_l4_port == '0)
            p.src_l4_port = 16'($urandom);
        if (p.dst_l4_port == '0)
            p.dst_l4_port = 16'($urandom);
        if (p.proto_in == '0)
            p.proto_in = 8'($urandom);
        if ($urandom_range(0, 1))
        begin
            t_hi = p.src_addr_hi;
            t_lo = p.src_addr_lo;
            t_port = p.src_l4_port;
            p.src_addr_hi = p.dst_addr_hi;
            p.src_addr_lo = p.dst_addr_lo;
            p.src_l4_port = p.dst_l4_port;
            p.dst_addr_hi = t_hi;
            p.dst_addr_lo = t_lo;
            p.dst_l4_port = t_port;
        end
        case ($urandom_range(0, 7))
            0: p.addr_family ^= 2'($urandom_range(1, 3));
            1: p.src_addr_lo[6'($urandom)] ^= 1'b1;
            2: p.dst_l4_port += 16'd1;
            3: p.proto_in ^= 8'h01;
            4: p.dst_addr_hi[6'($urandom)] ^= 1'b1;
            default: ;
        endcase
        return p;
    endfunction

    // Track table occupancy on the stimulus side so removes and matches aim at real entries.
    task automatic queue_item(wftf_pkg::req_t r);
        if (r.op == wftf_pkg::OP_ADD && stim_table.size() < MAX_FILTERS)
            stim_table.push_back(r);
        else if (r.op == wftf_pkg::OP_REMOVE && r.entry_index < stim_table.size())
            stim_table.delete(r.entry_index);
        pending_reqs.push_back(r);
    endtask

    task automatic check_field(string name, logic [4:0] want_v, logic [4:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
        end
    endtask

    initial
    begin
        wftf_pkg::req_t item;
        int grow;
        int roll;
        logic [63:0] ones;
        ones = '1;

        queue_item(mk(wftf_pkg::OP_MATCH, FAM_V4, 64'd0, 64'h0a000001, 64'd0, 64'h0a000002,
                      16'd1234, 16'd80, 8'd6, 4'd0));
        queue_item(mk(wftf_pkg::OP_REMOVE, FAM_V4, 64'd0, 64'd0, 64'd0, 64'd0,
                      16'd0, 16'd0, 8'd0, 4'd0));
        queue_item(mk(OP_UNUSED, FAM_ODD, ones, ones, ones, ones, '1, '1, '1, '1));
        queue_item(mk(wftf_pkg::OP_ADD, FAM_V4, 64'd0, 64'h0a000001, 64'd0, 64'h0a000002,
                      16'd1234, 16'd80, 8'd6, 4'd0));
        queue_item(mk(wftf_pkg::OP_MATCH, FAM_V4, 64'd0, 64'h0a000001, 64'd0, 64'h0a000002,
                      16'd1234, 16'd80, 8'd6, 4'd0));
        queue_item(mk(wftf_pkg::OP_MATCH, FAM_V4, 64'd0, 64'h0a000002, 64'd0, 64'h0a000001,
                      16'd80, 16'd1234, 8'd6, 4'd0));
        queue_item(mk(wftf_pkg::OP_MATCH, FAM_V4, 64'd0, 64'h0a000001, 64'd0, 64'h0a000002,
                      16'd1234, 16'd80, 8'd17, 4'd0));
        queue_item(mk(wftf_pkg::OP_MATCH, FAM_V6, 64'd0, 64'h0a000001, 64'd0, 64'h0a000002,
                      16'd1234, 16'd80, 8'd6, 4'd0));
        // IPv4 addresses still compare over the whole 128 bits
        queue_item(mk(wftf_pkg::OP_MATCH, FAM_V4, 64'd1, 64'h0a000001, 64'd0, 64'h0a000002,
                      16'd1234, 16'd80, 8'd6, 4'd0));
        queue_item(mk(wftf_pkg::OP_ADD, FAM_V6, ones, ones, ones, ones, '1, '1, '1, '1));
        queue_item(mk(wftf_pkg::OP_MATCH, FAM_V6, ones, ones, ones, ones, '1, '1, '1, '1));
        queue_item(mk(wftf_pkg::OP_ADD, FAM_NONE, 64'd0, 64'd0, 64'd0, 64'd0,
                      16'd0, 16'd53, 8'd17, 4'd0));
        queue_item(mk(wftf_pkg::OP_MATCH, FAM_V6, 64'h20010db8, 64'd5, 64'h20010db8, 64'd9,
                      16'd53, 16'd999, 8'd17, 4'd3));
        queue_item(mk(wftf_pkg::OP_ADD, FAM_ODD, 64'h1234, 64'h5678, 64'd0, 64'd0,
                      16'd0, 16'd0, 8'd0, 4'd7));
        queue_item(mk(wftf_pkg::OP_MATCH, FAM_ODD, 64'h1234, 64'h5678, 64'd7, 64'd7,
                      16'd7, 16'd7, 8'd7, 4'd7));
        queue_item(mk(wftf_pkg::OP_REMOVE, FAM_NONE, 64'd0, 64'd0, 64'd0, 64'd0,
                      16'd0, 16'd0, 8'd0, 4'd0));
        queue_item(mk(wftf_pkg::OP_MATCH, FAM_V4, 64'd0, 64'h0a000001, 64'd0, 64'h0a000002,
                      16'd1234, 16'd80, 8'd6, 4'd0));
        queue_item(mk(wftf_pkg::OP_REMOVE, FAM_NONE, 64'd0, 64'd0, 64'd0, 64'd0,
                      16'd0, 16'd0, 8'd0, 4'd15));
        queue_item(mk(wftf_pkg::OP_REMOVE, FAM_NONE, 64'd0, 64'd0, 64'd0, 64'd0,
                      16'd0, 16'd0, 8'd0, 4'd2));
        queue_item(mk(wftf_pkg::OP_ADD, FAM_NONE, 64'd0, 64'd0, 64'd0, 64'd0,
                      16'd0, 16'd0, 8'd0, 4'd0));
        queue_item(mk(wftf_pkg::OP_MATCH, FAM_V4, 64'd0, 64'hc0a80001, 64'd0, 64'hc0a80002,
                      16'd5, 16'd6, 8'd1, 4'd0));
        queue_item(mk(wftf_pkg::OP_REMOVE, FAM_NONE, 64'd0, 64'd0, 64'd0, 64'd0,
                      16'd0, 16'd0, 8'd0, 4'd0));
        queue_item(mk(wftf_pkg::OP_REMOVE, FAM_NONE, 64'd0, 64'd0, 64'd0, 64'd0,
                      16'd0, 16'd0, 8'd0, 4'd0));
        queue_item(mk(wftf_pkg::OP_REMOVE, FAM_NONE, 64'd0, 64'd0, 64'd0, 64'd0,
                      16'd0, 16'd0, 8'd0, 4'd0));

        grow = 1;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            // Every 60 items, pick at random between filling and draining the table
            if (k % 60 == 59)
                grow = $urandom_range(0, 1);
            roll = $urandom_range(0, 99);
            if (roll < 4)
                item = random_noise();
            else if (roll < 6)
            begin
                item = random_noise();
                item.op = OP_UNUSED;
            end
            else if (roll < 56)
            begin
                if (stim_table.size() != 0 && $urandom_range(0, 9) < 7)
                    item = packet_for(stim_table[$urandom_range(0, stim_table.size() - 1)]);
                else
                    item = random_packet();
            end
            else if (roll < (grow ? 90 : 65))
                item = random_filter();
            else
            begin
                item = random_noise();
                item.op = wftf_pkg::OP_REMOVE;
                if (stim_table.size() != 0 && $urandom_range(0, 9) < 8)
                    item.entry_index = 4'($urandom_range(0, stim_table.size() - 1));
            end
            queue_item(item);
        end
        n_total = pending_reqs.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d transactions: %0d matches (%0d hit), %0d adds (%0d table full),",
                 n_sent, n_matches, n_hits, n_adds, n_full);
        $display("%0d removes (%0d bad index), %0d results checked.", n_removes, n_bad, n_results);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap <= 0;
            quiet <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(apply_request(req));
                n_sent++;
            end
            quiet <= (n_sent + CALM_TAIL >= n_total);
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    req_valid <= 1'b0;
                else if (!quiet && $urandom_range(0, 9) == 0)
                begin
                    send_gap <= $urandom_range(0, 2);
                    req_valid <= 1'b0;
                end
                else
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            recv_stall <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                n_results++;
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none, got %p", $time, rsp);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("matched", 5'(want.matched), 5'(rsp.matched));
                    check_field("status", 5'(want.status), 5'(rsp.status));
                    check_field("entries_used", want.entries_used, rsp.entries_used);
                end
            end
            // Hold off once for a long stretch so the input side backs up
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && n_results >= HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                rsp_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                rsp_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                recv_stall <= $urandom_range(0, 2);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

endmodule
